// File: rtl/core/byte_count_to_binary_prefix_text_core_macros.svh
// Assertion helpers shared by the core.
`ifndef BYTE_COUNT_TO_BINARY_PREFIX_TEXT_CORE_MACROS_SVH
`define BYTE_COUNT_TO_BINARY_PREFIX_TEXT_CORE_MACROS_SVH

// Same-cycle implication.
`define BCBPT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bcbpt assertion failed");

// Next-cycle implication.
`define BCBPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bcbpt assertion failed");

`endif

// File: rtl/core/bcbpt_pkg.sv
package bcbpt_pkg;

   localparam int CountWidth = 64;
   localparam int CharWidth  = 7;
   localparam int StepShift  = 10;
   localparam int WholeWidth = 10;
   localparam int StepWidth  = 3;
   localparam int DigitWidth = 4;
   localparam int ProdWidth  = 14;
   localparam logic [StepWidth-1:0] MaxSteps = 3'd6;

   localparam logic [CharWidth-1:0] CharZero  = 7'h30;
   localparam logic [CharWidth-1:0] CharDot   = 7'h2E;
   localparam logic [CharWidth-1:0] CharSpace = 7'h20;
   localparam logic [CharWidth-1:0] CharI     = 7'h69;
   localparam logic [CharWidth-1:0] CharB     = 7'h42;

   localparam logic [1:0] PlaceThou = 2'd0;
   localparam logic [1:0] PlaceHund = 2'd1;
   localparam logic [1:0] PlaceTens = 2'd2;
   localparam logic [1:0] PlaceOnes = 2'd3;

   typedef enum logic [2:0] {
      SEL_DIGIT,
      SEL_DOT,
      SEL_FRAC,
      SEL_SPACE,
      SEL_PREFIX,
      SEL_I,
      SEL_B
   } char_sel_type;

   typedef struct packed {
      logic         load;
      logic         scale;
      logic         frac_load;
      logic [1:0]   place;
      logic         digit_take;
      logic         emit;
      char_sel_type sel;
      logic         last;
   } dp_cmd_type;

   typedef struct packed {
      logic scale_done;
      logic digit_nonzero;
      logic started;
      logic frac_nonzero;
      logic steps_zero;
      logic out_free;
   } dp_status_type;

   function automatic logic [WholeWidth-1:0] place_value(input logic [1:0] place);
      logic [WholeWidth-1:0] value;
      unique case (place)
         PlaceThou: value = 10'd1000;
         PlaceHund: value = 10'd100;
         PlaceTens: value = 10'd10;
         PlaceOnes: value = 10'd1;
         default:   value = 10'd1;
      endcase
      return value;
   endfunction

   function automatic logic [CharWidth-1:0] prefix_letter(input logic [StepWidth-1:0] steps);
      logic [CharWidth-1:0] code;
      unique case (steps)
         3'd1:    code = 7'h4B;
         3'd2:    code = 7'h4D;
         3'd3:    code = 7'h47;
         3'd4:    code = 7'h54;
         3'd5:    code = 7'h50;
         3'd6:    code = 7'h45;
         default: code = 7'h00;
      endcase
      return code;
   endfunction

endpackage

// File: rtl/core/bcbpt_ifs.sv
interface bcbpt_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] byte_count;

   modport source (output valid, output byte_count, input ready);
   modport sink (input valid, input byte_count, output ready);
endinterface

interface bcbpt_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] char_code;
   logic       last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink (input valid, input char_code, input last_char, output ready);
endinterface

// File: rtl/core/bcbpt_datapath.sv
module bcbpt_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [63:0]              byte_count_i,
   input  bcbpt_pkg::dp_cmd_type    cmd_i,
   output bcbpt_pkg::dp_status_type status_o,
   bcbpt_rsp_if.source              rsp
);
   import bcbpt_pkg::*;

   logic [CountWidth-1:0] whole_ff, whole_in;
   logic [CountWidth-1:0] low_ff, low_in;
   logic [StepWidth-1:0]  steps_ff, steps_in;
   logic [DigitWidth-1:0] frac_ff, frac_in;
   logic                  started_ff, started_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CharWidth-1:0]  char_ff, char_in;
   logic                  last_ff, last_in;

   logic [WholeWidth-1:0] place;
   logic [DigitWidth-1:0] digit;
   logic [ProdWidth-1:0]  sub;
   logic [ProdWidth-1:0]  prod;
   logic [CountWidth+3:0] ten_low;
   logic [CharWidth-1:0]  char_sel;
   logic                  out_free;

   assign place   = place_value(cmd_i.place);
   assign ten_low = {1'b0, low_ff, 3'b000} + {3'b000, low_ff, 1'b0};
   assign out_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      digit = '0;
      sub   = '0;
      prod  = '0;
      for (int i = 1; i < 10; i++) begin
         prod = ProdWidth'(i) * {{(ProdWidth-WholeWidth){1'b0}}, place};
         if ({{(ProdWidth-WholeWidth){1'b0}}, whole_ff[WholeWidth-1:0]} >= prod) begin
            digit = DigitWidth'(i);
            sub   = prod;
         end
      end
   end

   always_comb begin
      unique case (cmd_i.sel)
         SEL_DIGIT:  char_sel = CharZero + {3'b000, digit};
         SEL_DOT:    char_sel = CharDot;
         SEL_FRAC:   char_sel = CharZero + {3'b000, frac_ff};
         SEL_SPACE:  char_sel = CharSpace;
         SEL_PREFIX: char_sel = prefix_letter(steps_ff);
         SEL_I:      char_sel = CharI;
         SEL_B:      char_sel = CharB;
         default:    char_sel = CharB;
      endcase
   end

   always_comb begin
      whole_in   = whole_ff;
      low_in     = low_ff;
      steps_in   = steps_ff;
      frac_in    = frac_ff;
      started_in = started_ff;
      if (cmd_i.load) begin
         whole_in   = byte_count_i;
         low_in     = '0;
         steps_in   = '0;
         started_in = 1'b0;
      end else if (cmd_i.scale) begin
         whole_in = whole_ff >> StepShift;
         low_in   = {whole_ff[StepShift-1:0], low_ff[CountWidth-1:StepShift]};
         steps_in = steps_ff + 3'd1;
      end else if (cmd_i.digit_take) begin
         whole_in   = whole_ff - {{(CountWidth-WholeWidth){1'b0}}, sub[WholeWidth-1:0]};
         started_in = 1'b1;
      end
      if (cmd_i.frac_load) begin
         frac_in = ten_low[CountWidth+3:CountWidth];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      if (cmd_i.emit) begin
         rsp_valid_in = 1'b1;
         char_in      = char_sel;
         last_in      = cmd_i.last;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      whole_ff   <= whole_in;
      low_ff     <= low_in;
      steps_ff   <= steps_in;
      frac_ff    <= frac_in;
      started_ff <= started_in;
      char_ff    <= char_in;
      last_ff    <= last_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.char_code = char_ff;
   assign rsp.last_char = last_ff;

   assign status_o.scale_done    = (whole_ff[CountWidth-1:StepShift] == '0)
                                   || (steps_ff == MaxSteps);
   assign status_o.digit_nonzero = (digit != '0);
   assign status_o.started       = started_ff;
   assign status_o.frac_nonzero  = (frac_ff != '0);
   assign status_o.steps_zero    = (steps_ff == '0);
   assign status_o.out_free      = out_free;

endmodule

// File: rtl/core/bcbpt_controller.sv
`include "byte_count_to_binary_prefix_text_core_macros.svh"

module bcbpt_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  bcbpt_pkg::dp_status_type status_i,
   output bcbpt_pkg::dp_cmd_type    cmd_o
);
   import bcbpt_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SCALE = 4'd1;
   localparam logic [3:0] S_THOU  = 4'd2;
   localparam logic [3:0] S_HUND  = 4'd3;
   localparam logic [3:0] S_TENS  = 4'd4;
   localparam logic [3:0] S_ONES  = 4'd5;
   localparam logic [3:0] S_DOT   = 4'd6;
   localparam logic [3:0] S_FRAC  = 4'd7;
   localparam logic [3:0] S_SPACE = 4'd8;
   localparam logic [3:0] S_PREF  = 4'd9;
   localparam logic [3:0] S_ISUF  = 4'd10;
   localparam logic [3:0] S_BCHR  = 4'd11;

   logic [3:0] state_ff, state_in;
   logic       want_digit;

   assign req_ready  = (state_ff == S_IDLE);
   assign want_digit = status_i.digit_nonzero || status_i.started;

   always_comb begin
      state_in         = state_ff;
      cmd_o            = '0;
      cmd_o.sel        = SEL_DIGIT;
      cmd_o.place      = PlaceOnes;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_o.load = 1'b1;
               state_in   = S_SCALE;
            end
         end
         S_SCALE: begin
            if (!status_i.scale_done) begin
               cmd_o.scale = 1'b1;
            end else begin
               cmd_o.frac_load = 1'b1;
               state_in        = S_THOU;
            end
         end
         S_THOU, S_HUND, S_TENS: begin
            unique case (state_ff)
               S_THOU:  cmd_o.place = PlaceThou;
               S_HUND:  cmd_o.place = PlaceHund;
               default: cmd_o.place = PlaceTens;
            endcase
            if (!want_digit || status_i.out_free) begin
               state_in = state_ff + 4'd1;
            end
            if (want_digit && status_i.out_free) begin
               cmd_o.emit       = 1'b1;
               cmd_o.digit_take = 1'b1;
            end
         end
         S_ONES: begin
            if (status_i.out_free) begin
               cmd_o.emit       = 1'b1;
               cmd_o.digit_take = 1'b1;
               state_in         = S_DOT;
            end
         end
         S_DOT: begin
            cmd_o.sel = SEL_DOT;
            if (!status_i.frac_nonzero) begin
               state_in = S_SPACE;
            end else if (status_i.out_free) begin
               cmd_o.emit = 1'b1;
               state_in   = S_FRAC;
            end
         end
         S_FRAC: begin
            cmd_o.sel = SEL_FRAC;
            if (status_i.out_free) begin
               cmd_o.emit = 1'b1;
               state_in   = S_SPACE;
            end
         end
         S_SPACE: begin
            cmd_o.sel = SEL_SPACE;
            if (status_i.out_free) begin
               cmd_o.emit = 1'b1;
               state_in   = status_i.steps_zero ? S_BCHR : S_PREF;
            end
         end
         S_PREF: begin
            cmd_o.sel = SEL_PREFIX;
            if (status_i.out_free) begin
               cmd_o.emit = 1'b1;
               state_in   = S_ISUF;
            end
         end
         S_ISUF: begin
            cmd_o.sel = SEL_I;
            if (status_i.out_free) begin
               cmd_o.emit = 1'b1;
               state_in   = S_BCHR;
            end
         end
         S_BCHR: begin
            cmd_o.sel = SEL_B;
            if (status_i.out_free) begin
               cmd_o.emit = 1'b1;
               cmd_o.last = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `BCBPT_ASSERT_IMPL(a_emit_needs_slot, clock, reset, cmd_o.emit, status_i.out_free)
   `BCBPT_ASSERT_IMPL(a_last_only_on_b, clock, reset, cmd_o.last, cmd_o.emit && state_ff == S_BCHR)
   `BCBPT_ASSERT_NEXT(a_accept_starts_scale, clock, reset, req_valid && req_ready, state_ff == S_SCALE)

endmodule

// File: rtl/core/byte_count_to_binary_prefix_text_core.sv
// Sequence: once an item is accepted, the count is divided by 1024 k times (k =
// number of 1024 steps, 0..6), one scaling step per cycle; then the four digit slots
// go thousands to ones; a leading slot above ones with no digit emits nothing.
// A new item is accepted only after the previous one's last character has entered
// the result register, at most one character per cycle and only while it is free.
// Reset: synchronous, active high; clears the sequencer and the result valid.
module byte_count_to_binary_prefix_text_core (
   input  logic        clock,
   input  logic        reset,
   bcbpt_req_if.sink   req_ch,
   bcbpt_rsp_if.source rsp_ch
);
   import bcbpt_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          req_ready;

   assign req_ch.ready = req_ready;

   bcbpt_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status_i  (status),
      .cmd_o     (cmd)
   );

   bcbpt_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .byte_count_i (req_ch.byte_count),
      .cmd_i        (cmd),
      .status_o     (status),
      .rsp          (rsp_ch)
   );

endmodule

// File: dv/byte_count_to_binary_prefix_text_core_tb.sv
module byte_count_to_binary_prefix_text_core_tb;
   import bcbpt_pkg::*;

   localparam int CycleLimit = 500000;
   localparam int DrainCycles = 40;
   localparam logic [47:0] PrefixText = "KMGTPE";

   typedef struct {
      logic [CharWidth-1:0] code;
      logic                 last;
   } text_char_type;

   logic clock;
   logic reset;

   bcbpt_req_if req_ch();
   bcbpt_rsp_if rsp_ch();

   byte_count_to_binary_prefix_text_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   text_char_type expected_text[$];
   int            counts_sent;
   int            chars_checked = 0;
   int            mismatches = 0;
   int            cycles = 0;
   int            rsp_wait;
   bit            no_idle;

   initial begin
      clock = 1'b0;
   end

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Build the expected character string for one byte count.
   function automatic void predict_size_text(input logic [63:0] count);
      logic [63:0]           whole;
      logic [63:0]           mask;
      logic [67:0]           scaled;
      logic [3:0]            frac;
      logic [WholeWidth-1:0] digits;
      logic [WholeWidth-1:0] place;
      int                    steps;
      int                    shift;
      bit                    started;
      logic [CharWidth-1:0]  chars[$];
      text_char_type         entry;
      whole = count;
      steps = 0;
      frac = 4'd0;
      started = 1'b0;
      while (whole >= 64'd1024 && steps < 6) begin
         whole = whole >> StepShift;
         steps++;
      end
      shift = steps * StepShift;
      if (steps != 0) begin
         mask = (64'd1 << shift) - 64'd1;
         scaled = ({4'd0, count & mask} * 68'd10) >> shift;
         frac = scaled[3:0];
      end
      digits = whole[WholeWidth-1:0];
      place = 10'd1000;
      while (place != 10'd0) begin
         if (started || digits >= place) begin
            chars.push_back(CharZero + CharWidth'((digits / place) % 10));
            digits = digits % place;
            started = 1'b1;
         end
         place = place / 10'd10;
      end
      if (!started) begin
         chars.push_back(CharZero);
      end
      if (frac != 4'd0) begin
         chars.push_back(CharDot);
         chars.push_back(CharZero + CharWidth'(frac));
      end
      chars.push_back(CharSpace);
      if (steps != 0) begin
         chars.push_back(PrefixText[8*(6-steps) +: CharWidth]);
         chars.push_back(CharI);
      end
      chars.push_back(CharB);
      foreach (chars[i]) begin
         entry.code = chars[i];
         entry.last = (i == chars.size() - 1);
         expected_text.push_back(entry);
      end
   endfunction

   // Offer one count and hold it until accepted.
   task automatic send_count(input logic [63:0] count);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.byte_count <= count;
      predict_size_text(count);
      counts_sent++;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // Receive side: random stalls and result checking.
   always @(posedge clock) begin
      text_char_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            chars_checked++;
            if (expected_text.size() == 0) begin
               mismatches++;
               $display("%0t unexpected char: expected none, got code %h last %b",
                        $time, rsp_ch.char_code, rsp_ch.last_char);
            end else begin
               want = expected_text.pop_front();
               if (rsp_ch.char_code !== want.code) begin
                  mismatches++;
                  $display("%0t char_code: expected %h, got %h",
                           $time, want.code, rsp_ch.char_code);
               end
               if (rsp_ch.last_char !== want.last) begin
                  mismatches++;
                  $display("%0t last_char: expected %b, got %b",
                           $time, want.last, rsp_ch.last_char);
               end
            end
            rsp_wait = no_idle ? 0 : $urandom_range(0, 15);
         end else if (rsp_wait != 0) begin
            rsp_wait--;
         end
         rsp_ch.ready <= (rsp_wait == 0);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CycleLimit) begin
         $display("%0t timeout with %0d chars outstanding", $time, expected_text.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic test_small_counts();
      send_count(64'd0);
      send_count(64'd1);
      send_count(64'd9);
      send_count(64'd99);
      send_count(64'd999);
      send_count(64'd1000);
      send_count(64'd1023);
   endtask

   task automatic test_fraction_digit();
      send_count(64'd1024);
      send_count(64'd1126);
      send_count(64'd1535);
      send_count(64'd1536);
      send_count((64'd1 << 20) - 64'd1);
      send_count(64'd1000 << 30);
   endtask

   task automatic test_prefix_bounds();
      send_count(64'd1 << 20);
      send_count(64'd1 << 30);
      send_count(64'd1 << 40);
      send_count(64'd1 << 50);
      send_count((64'd1 << 60) - 64'd1);
      send_count(64'd1 << 60);
      send_count((64'd10 << 60) + (64'd1 << 59));
      send_count({64{1'b1}});
   endtask

   // Pick a prefix step, then a count within that step's range.
   task automatic test_random_by_scale(input int n);
      int          k;
      logic [63:0] value;
      repeat (n) begin
         k = $urandom_range(0, 6);
         value = random_word();
         if (k < 6) begin
            value = value & ((64'd1 << (StepShift * (k + 1))) - 64'd1);
         end
         if (k != 0) begin
            value[StepShift*k + $urandom_range(0, 9) - ((k == 6) ? 6 : 0)] = 1'b1;
         end
         send_count(value);
      end
   endtask

   task automatic test_random_full_width(input int n);
      repeat (n) send_count(random_word());
   endtask

   task automatic test_random_small(input int n);
      repeat (n) send_count(64'($urandom_range(0, 20000)));
   endtask

   task automatic test_back_to_back(input int n);
      no_idle = 1'b1;
      test_random_by_scale(n);
      no_idle = 1'b0;
   endtask

   initial begin
      counts_sent = 0;
      no_idle = 1'b0;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.byte_count <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_small_counts();
      test_fraction_digit();
      test_prefix_bounds();
      test_random_by_scale(300);
      test_back_to_back(20);
      test_random_full_width(100);
      test_random_small(30);

      req_ch.valid <= 1'b0;
      while (expected_text.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("covered %0d byte counts, %0d characters, all seven prefix steps",
               counts_sent, chars_checked);
      $display("random stalls on both sides plus one back-to-back stretch");
      if (mismatches == 0 && expected_text.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// File: byte_count_to_binary_prefix_text_core.f
+incdir+rtl/core
rtl/core/bcbpt_pkg.sv
rtl/core/bcbpt_ifs.sv
rtl/core/bcbpt_datapath.sv
rtl/core/bcbpt_controller.sv
rtl/core/byte_count_to_binary_prefix_text_core.sv
dv/byte_count_to_binary_prefix_text_core_tb.sv
